// ===== rtl/apc_pkg.sv =====
// Shared types, codes and the control store of the animation playback clock.
// Used by every module of the block; depends on nothing.
package apc_pkg;

	// Position width, Q16.16.
	localparam int FRAME_BITS = 32;
	localparam int ACT_W      = 3;
	localparam int DT_W       = 16;
	localparam int SPD_W      = 16;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 2;
	// Q4.12 times Q8.8 is Q12.20; dropping four bits leaves Q12.16.
	localparam int INC_SHIFT  = 4;
	localparam int INC_W      = DT_W + SPD_W - INC_SHIFT;
	localparam int ACC_W      = FRAME_BITS + 1;
	localparam int DIV_CNT_W  = $clog2(ACC_W + 1);

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_TICK     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PLAY     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_STOP     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SETFRAME = 3'd3;
	localparam logic [ACT_W-1:0] ACT_GOSTART  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_GOEND    = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 2'd3;

	// Datapath operations.
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
	localparam logic [OP_W-1:0] OP_LATCH       = 5'd1;
	localparam logic [OP_W-1:0] OP_PLAY        = 5'd2;
	localparam logic [OP_W-1:0] OP_STOP        = 5'd3;
	localparam logic [OP_W-1:0] OP_SETFRAME    = 5'd4;
	localparam logic [OP_W-1:0] OP_GOSTART     = 5'd5;
	localparam logic [OP_W-1:0] OP_GOEND       = 5'd6;
	localparam logic [OP_W-1:0] OP_MUL         = 5'd7;
	localparam logic [OP_W-1:0] OP_FSUM        = 5'd8;
	localparam logic [OP_W-1:0] OP_RDIFF       = 5'd9;
	localparam logic [OP_W-1:0] OP_POS_ACC     = 5'd10;
	localparam logic [OP_W-1:0] OP_POS_SUB     = 5'd11;
	localparam logic [OP_W-1:0] OP_CLAMP_END   = 5'd12;
	localparam logic [OP_W-1:0] OP_CLAMP_START = 5'd13;
	localparam logic [OP_W-1:0] OP_POS_ZERO    = 5'd14;
	localparam logic [OP_W-1:0] OP_DIV_START   = 5'd15;
	localparam logic [OP_W-1:0] OP_POS_REM     = 5'd16;
	localparam logic [OP_W-1:0] OP_POS_LEN_REM = 5'd17;

	// Branch conditions: jump to the target when true, else fall through.
	localparam int COND_W = 4;
	localparam logic [COND_W-1:0] C_NEXT       = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
	localparam logic [COND_W-1:0] C_DISPATCH   = 4'd2;
	localparam logic [COND_W-1:0] C_NOT_RUN    = 4'd3;
	localparam logic [COND_W-1:0] C_REVERSE    = 4'd4;
	localparam logic [COND_W-1:0] C_NOT_PAST   = 4'd5;
	localparam logic [COND_W-1:0] C_NOT_LOOP   = 4'd6;
	localparam logic [COND_W-1:0] C_LEN_ZERO   = 4'd7;
	localparam logic [COND_W-1:0] C_NOT_BEHIND = 4'd8;

	// What a step waits for before it executes.
	localparam int WT_W = 2;
	localparam logic [WT_W-1:0] W_NONE = 2'd0;
	localparam logic [WT_W-1:0] W_IN   = 2'd1;
	localparam logic [WT_W-1:0] W_EMIT = 2'd2;
	localparam logic [WT_W-1:0] W_DIV  = 2'd3;

	// Frame source of an emitted item.
	localparam int ESRC_W = 2;
	localparam logic [ESRC_W-1:0] ES_POS  = 2'd0;
	localparam logic [ESRC_W-1:0] ES_LEN  = 2'd1;
	localparam logic [ESRC_W-1:0] ES_ZERO = 2'd2;

	// Control store addresses.
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] A_IDLE        = 5'd0;
	localparam logic [PC_W-1:0] A_DECODE      = 5'd1;
	localparam logic [PC_W-1:0] A_TICK        = 5'd2;
	localparam logic [PC_W-1:0] A_MUL         = 5'd3;
	localparam logic [PC_W-1:0] A_DIR         = 5'd4;
	localparam logic [PC_W-1:0] A_FSUM        = 5'd5;
	localparam logic [PC_W-1:0] A_FPAST       = 5'd6;
	localparam logic [PC_W-1:0] A_FLOOP       = 5'd7;
	localparam logic [PC_W-1:0] A_FEMIT       = 5'd8;
	localparam logic [PC_W-1:0] A_FLEN0       = 5'd9;
	localparam logic [PC_W-1:0] A_FDIV        = 5'd10;
	localparam logic [PC_W-1:0] A_FREM        = 5'd11;
	localparam logic [PC_W-1:0] A_CLAMP_END   = 5'd12;
	localparam logic [PC_W-1:0] A_FSTORE      = 5'd13;
	localparam logic [PC_W-1:0] A_REV         = 5'd14;
	localparam logic [PC_W-1:0] A_RLOOP       = 5'd15;
	localparam logic [PC_W-1:0] A_REMIT       = 5'd16;
	localparam logic [PC_W-1:0] A_RLEN0       = 5'd17;
	localparam logic [PC_W-1:0] A_RDIFF       = 5'd18;
	localparam logic [PC_W-1:0] A_RDIV        = 5'd19;
	localparam logic [PC_W-1:0] A_RREM        = 5'd20;
	localparam logic [PC_W-1:0] A_CLAMP_START = 5'd21;
	localparam logic [PC_W-1:0] A_RSUB        = 5'd22;
	localparam logic [PC_W-1:0] A_ZERO        = 5'd23;
	localparam logic [PC_W-1:0] A_EMIT        = 5'd24;
	localparam logic [PC_W-1:0] A_PLAY        = 5'd25;
	localparam logic [PC_W-1:0] A_STOP        = 5'd26;
	localparam logic [PC_W-1:0] A_SETFRAME    = 5'd27;
	localparam logic [PC_W-1:0] A_GOSTART     = 5'd28;
	localparam logic [PC_W-1:0] A_GOEND       = 5'd29;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
		logic [WT_W-1:0]   wt;
		logic [ESRC_W-1:0] esrc;
		logic              elast;
	} ucw_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] length;
		logic [SPD_W-1:0]      speed;
		logic                  loop_mode;
		logic                  reverse;
	} cfg_t;

	typedef struct packed {
		logic              fire;
		logic [OP_W-1:0]   op;
		logic              emit;
		logic [ESRC_W-1:0] esrc;
		logic              elast;
	} dp_ctl_t;

	typedef struct packed {
		logic             running;
		logic             reverse;
		logic             past;
		logic             loop_mode;
		logic             len_zero;
		logic             not_behind;
		logic             out_free;
		logic             div_busy;
		logic [ACT_W-1:0] action;
	} dp_flags_t;

	function automatic ucw_t uc(input logic [OP_W-1:0] op, input logic [COND_W-1:0] cond,
			input logic [PC_W-1:0] target, input logic [WT_W-1:0] wt,
			input logic [ESRC_W-1:0] esrc, input logic elast);
		ucw_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		w.wt     = wt;
		w.esrc   = esrc;
		w.elast  = elast;
		return w;
	endfunction

	// The control program.
	function automatic ucw_t ucode_word(input logic [PC_W-1:0] addr);
		ucw_t w;
		unique case (addr)
			A_IDLE:        w = uc(OP_LATCH, C_NEXT, A_IDLE, W_IN, ES_POS, 1'b0);
			A_DECODE:      w = uc(OP_NONE, C_DISPATCH, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_TICK:        w = uc(OP_NONE, C_NOT_RUN, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_MUL:         w = uc(OP_MUL, C_NEXT, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_DIR:         w = uc(OP_NONE, C_REVERSE, A_REV, W_NONE, ES_POS, 1'b0);
			A_FSUM:        w = uc(OP_FSUM, C_NEXT, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_FPAST:       w = uc(OP_NONE, C_NOT_PAST, A_FSTORE, W_NONE, ES_POS, 1'b0);
			A_FLOOP:       w = uc(OP_NONE, C_NOT_LOOP, A_CLAMP_END, W_NONE, ES_POS, 1'b0);
			A_FEMIT:       w = uc(OP_NONE, C_NEXT, A_IDLE, W_EMIT, ES_LEN, 1'b0);
			A_FLEN0:       w = uc(OP_NONE, C_LEN_ZERO, A_ZERO, W_NONE, ES_POS, 1'b0);
			A_FDIV:        w = uc(OP_DIV_START, C_NEXT, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_FREM:        w = uc(OP_POS_REM, C_ALWAYS, A_EMIT, W_DIV, ES_POS, 1'b0);
			A_CLAMP_END:   w = uc(OP_CLAMP_END, C_ALWAYS, A_EMIT, W_NONE, ES_POS, 1'b0);
			A_FSTORE:      w = uc(OP_POS_ACC, C_ALWAYS, A_EMIT, W_NONE, ES_POS, 1'b0);
			A_REV:         w = uc(OP_NONE, C_NOT_BEHIND, A_RSUB, W_NONE, ES_POS, 1'b0);
			A_RLOOP:       w = uc(OP_NONE, C_NOT_LOOP, A_CLAMP_START, W_NONE, ES_POS, 1'b0);
			A_REMIT:       w = uc(OP_NONE, C_NEXT, A_IDLE, W_EMIT, ES_ZERO, 1'b0);
			A_RLEN0:       w = uc(OP_NONE, C_LEN_ZERO, A_ZERO, W_NONE, ES_POS, 1'b0);
			A_RDIFF:       w = uc(OP_RDIFF, C_NEXT, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_RDIV:        w = uc(OP_DIV_START, C_NEXT, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_RREM:        w = uc(OP_POS_LEN_REM, C_ALWAYS, A_EMIT, W_DIV, ES_POS, 1'b0);
			A_CLAMP_START: w = uc(OP_CLAMP_START, C_ALWAYS, A_EMIT, W_NONE, ES_POS, 1'b0);
			A_RSUB:        w = uc(OP_POS_SUB, C_ALWAYS, A_EMIT, W_NONE, ES_POS, 1'b0);
			A_ZERO:        w = uc(OP_POS_ZERO, C_NEXT, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_EMIT:        w = uc(OP_NONE, C_ALWAYS, A_IDLE, W_EMIT, ES_POS, 1'b1);
			A_PLAY:        w = uc(OP_PLAY, C_ALWAYS, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_STOP:        w = uc(OP_STOP, C_ALWAYS, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_SETFRAME:    w = uc(OP_SETFRAME, C_ALWAYS, A_IDLE, W_NONE, ES_POS, 1'b0);
			A_GOSTART:     w = uc(OP_GOSTART, C_ALWAYS, A_EMIT, W_NONE, ES_POS, 1'b0);
			A_GOEND:       w = uc(OP_GOEND, C_ALWAYS, A_EMIT, W_NONE, ES_POS, 1'b0);
			default:       w = uc(OP_NONE, C_ALWAYS, A_IDLE, W_NONE, ES_POS, 1'b0);
		endcase
		return w;
	endfunction

	// Entry point of each action's routine.
	function automatic logic [PC_W-1:0] dispatch_target(input logic [ACT_W-1:0] action);
		logic [PC_W-1:0] t;
		unique case (action)
			ACT_TICK:     t = A_TICK;
			ACT_PLAY:     t = A_PLAY;
			ACT_STOP:     t = A_STOP;
			ACT_SETFRAME: t = A_SETFRAME;
			ACT_GOSTART:  t = A_GOSTART;
			ACT_GOEND:    t = A_GOEND;
			default:      t = A_IDLE;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/apc_divider.sv =====
// Restoring divider of the animation playback clock: one quotient bit a cycle,
// only the remainder is kept. Depends on apc_pkg.
module apc_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [apc_pkg::ACC_W-1:0]      dividend,
	input  logic [apc_pkg::FRAME_BITS-1:0] divisor,
	output logic                          busy,
	output logic [apc_pkg::FRAME_BITS-1:0] rem
);
	import apc_pkg::*;

	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [ACC_W-1:0]      dvd_q;
	logic [FRAME_BITS-1:0] dvs_q;
	logic [FRAME_BITS-1:0] rem_q;
	logic [ACC_W-1:0]      shifted;
	logic [ACC_W-1:0]      diff;

	assign busy    = (cnt_q != '0);
	assign rem     = rem_q;
	assign shifted = {rem_q, dvd_q[ACC_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(ACC_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[ACC_W-2:0], 1'b0};
			if (shifted >= {1'b0, dvs_q}) begin
				rem_q <= diff[FRAME_BITS-1:0];
			end else begin
				rem_q <= shifted[FRAME_BITS-1:0];
			end
		end
	end

endmodule

// ===== rtl/apc_datapath.sv =====
// Datapath of the animation playback clock: position state, tick arithmetic,
// remainder unit and the output register. Depends on apc_pkg and apc_divider.
module apc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apc_pkg::cfg_t                 cfg,
	input  apc_pkg::dp_ctl_t              ctl,
	output apc_pkg::dp_flags_t            flags,
	input  logic [apc_pkg::ACT_W-1:0]      action,
	input  logic [apc_pkg::DT_W-1:0]       delta_time,
	input  logic [apc_pkg::FRAME_BITS-1:0] new_frame,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [apc_pkg::FRAME_BITS-1:0] frame_pos,
	output logic [apc_pkg::FRAME_BITS-1:0] previous_pos,
	output logic                          playing,
	output logic                          last
);
	import apc_pkg::*;

	logic [ACT_W-1:0]      act_q;
	logic [DT_W-1:0]       delta_q;
	logic [FRAME_BITS-1:0] nf_q;
	logic [FRAME_BITS-1:0] pos_q;
	logic [FRAME_BITS-1:0] prev_q;
	logic                  run_q;
	logic [INC_W-1:0]      inc_q;
	logic [ACC_W-1:0]      acc_q;
	logic                  out_valid_q;
	logic [FRAME_BITS-1:0] out_frame_q;
	logic [FRAME_BITS-1:0] out_prev_q;
	logic                  out_play_q;
	logic                  out_last_q;

	logic [DT_W+SPD_W-1:0] product;
	logic [FRAME_BITS-1:0] inc_ext;
	logic [FRAME_BITS-1:0] emit_frame;
	logic [FRAME_BITS-1:0] rem;
	logic                  div_busy;
	logic                  div_start;

	assign product   = delta_q * cfg.speed;
	assign inc_ext   = FRAME_BITS'(inc_q);
	assign div_start = ctl.fire && (ctl.op == OP_DIV_START);

	apc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (cfg.length),
		.busy     (div_busy),
		.rem      (rem)
	);

	// Position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= '0;
			run_q  <= 1'b0;
		end else if (ctl.fire) begin
			case (ctl.op)
				OP_PLAY: run_q <= 1'b1;
				OP_STOP: run_q <= 1'b0;
				OP_SETFRAME: begin
					prev_q <= pos_q;
					pos_q  <= nf_q;
				end
				OP_GOSTART: begin
					pos_q  <= '0;
					prev_q <= '0;
				end
				OP_GOEND: begin
					pos_q  <= cfg.length;
					prev_q <= cfg.length;
				end
				OP_MUL:     prev_q <= pos_q;
				OP_POS_ACC: pos_q  <= acc_q[FRAME_BITS-1:0];
				OP_POS_SUB: pos_q  <= pos_q - inc_ext;
				OP_CLAMP_END: begin
					pos_q <= cfg.length;
					run_q <= 1'b0;
				end
				OP_CLAMP_START: begin
					pos_q <= '0;
					run_q <= 1'b0;
				end
				OP_POS_ZERO:    pos_q <= '0;
				OP_POS_REM:     pos_q <= rem;
				OP_POS_LEN_REM: pos_q <= cfg.length - rem;
				default: ;
			endcase
		end
	end

	// Item capture and working registers.
	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			case (ctl.op)
				OP_LATCH: begin
					act_q   <= action;
					delta_q <= delta_time;
					nf_q    <= new_frame;
				end
				OP_MUL:   inc_q <= product[DT_W+SPD_W-1:INC_SHIFT];
				OP_FSUM:  acc_q <= {1'b0, pos_q} + ACC_W'(inc_q);
				OP_RDIFF: acc_q <= {1'b0, cfg.length} + ACC_W'(inc_q) - {1'b0, pos_q};
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ctl.esrc)
			ES_LEN:  emit_frame = cfg.length;
			ES_ZERO: emit_frame = '0;
			default: emit_frame = pos_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_frame_q <= emit_frame;
			out_prev_q  <= prev_q;
			out_play_q  <= run_q;
			out_last_q  <= ctl.elast;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_pos    = out_frame_q;
	assign previous_pos = out_prev_q;
	assign playing      = out_play_q;
	assign last         = out_last_q;

	always_comb begin
		flags.running    = run_q;
		flags.reverse    = cfg.reverse;
		flags.past       = (acc_q > {1'b0, cfg.length});
		flags.loop_mode  = cfg.loop_mode;
		flags.len_zero   = (cfg.length == '0);
		flags.not_behind = (inc_ext <= pos_q);
		flags.out_free   = !out_valid_q || !out_stall;
		flags.div_busy   = div_busy;
		flags.action     = act_q;
	end

endmodule

// ===== rtl/apc_sequencer.sv =====
// Microcode sequencer of the animation playback clock: step counter, control
// store lookup, wait handling and conditional jumps. Depends on apc_pkg.
module apc_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  apc_pkg::dp_flags_t flags,
	output apc_pkg::dp_ctl_t   ctl
);
	import apc_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ucw_t            uw;
	logic            hold;
	logic            take;

	assign uw = ucode_word(pc_q);

	always_comb begin
		unique case (uw.wt)
			W_IN:    hold = !in_valid;
			W_EMIT:  hold = !flags.out_free;
			W_DIV:   hold = flags.div_busy;
			default: hold = 1'b0;
		endcase
	end

	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:     take = 1'b1;
			C_NOT_RUN:    take = !flags.running;
			C_REVERSE:    take = flags.reverse;
			C_NOT_PAST:   take = !flags.past;
			C_NOT_LOOP:   take = !flags.loop_mode;
			C_LEN_ZERO:   take = flags.len_zero;
			C_NOT_BEHIND: take = flags.not_behind;
			default:      take = 1'b0;
		endcase
	end

	always_comb begin
		if (hold) begin
			pc_next = pc_q;
		end else if (uw.cond == C_DISPATCH) begin
			pc_next = dispatch_target(flags.action);
		end else if (take) begin
			pc_next = uw.target;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign in_stall = (pc_q != A_IDLE);

	always_comb begin
		ctl.fire  = !hold;
		ctl.op    = uw.op;
		ctl.emit  = (uw.wt == W_EMIT) && !hold;
		ctl.esrc  = uw.esrc;
		ctl.elast = uw.elast;
	end

endmodule

// ===== rtl/animation_playback_clock.sv =====
// Top level of the animation playback clock: configuration registers, the
// microcode sequencer and the datapath. Depends on apc_pkg and its submodules.
//
// The block keeps an animation position in unsigned Q16.16 together with the
// previous position and a playing flag, and works one command item at a time.
// A new item is taken only when the sequencer is back at its idle step; play,
// stop and set frame give no result. Go to start and go to end give one
// result each. A tick while playing, forward or backward, gives one result
// when the position stays inside the animation; when it wraps, the remainder
// by the programmed length comes from a restoring divider that yields one
// bit a cycle, and a wrap gives two results (the boundary frame, then the
// wrapped frame, marked last). Results go out through an output register,
// so the next item can be taken while a result still waits; a step that
// emits holds until that register is free. Configuration is written through
// cfg_we, cfg_index and cfg_data and should only change while the block is
// idle.
module animation_playback_clock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [apc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apc_pkg::CFG_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [apc_pkg::ACT_W-1:0]      action,
	input  logic [apc_pkg::DT_W-1:0]       delta_time,
	input  logic [apc_pkg::FRAME_BITS-1:0] new_frame,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [apc_pkg::FRAME_BITS-1:0] frame_pos,
	output logic [apc_pkg::FRAME_BITS-1:0] previous_pos,
	output logic                          playing,
	output logic                          last
);
	import apc_pkg::*;

	cfg_t      cfg_q;
	dp_ctl_t   ctl;
	dp_flags_t flags;

	// Configuration registers. The reset defaults give a one-frame loop
	// played forward at unit speed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length    <= FRAME_BITS'(65536);
			cfg_q.speed     <= SPD_W'(256);
			cfg_q.loop_mode <= 1'b1;
			cfg_q.reverse   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LENGTH:  cfg_q.length    <= cfg_data[FRAME_BITS-1:0];
				REG_SPEED:   cfg_q.speed     <= cfg_data[SPD_W-1:0];
				REG_LOOP:    cfg_q.loop_mode <= cfg_data[0];
				REG_REVERSE: cfg_q.reverse   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The sequencer steps through the control program and tells the
	// datapath which operation to perform and when to emit an item.
	apc_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.flags    (flags),
		.ctl      (ctl)
	);

	// The datapath holds the position state and drives the output channel.
	apc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.ctl          (ctl),
		.flags        (flags),
		.action       (action),
		.delta_time   (delta_time),
		.new_frame    (new_frame),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.frame_pos    (frame_pos),
		.previous_pos (previous_pos),
		.playing      (playing),
		.last         (last)
	);

endmodule

// ===== tb/tb_animation_playback_clock.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for animation_playback_clock: sends command items, predicts
// every frame result with its own model of the playback clock and checks the output.
// Depends on apc_pkg and the block's RTL only.
module tb_animation_playback_clock;
	import apc_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 5;
	localparam int IDLE_PCT        = 37;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int RANDOM_PHASES   = 8;
	// A tick that wraps spends most of its time in the divider; the pause
	// before a register write must outlast any item that is still in flight
	// without a result.
	localparam int SETTLE_CYCLES   = 80;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_LIMIT  = 4000;

	// The action field has two codes that the block must ignore.
	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

	// One frame in Q16.16 and one time unit in Q4.12.
	localparam logic [FRAME_BITS-1:0] ONE_FRAME = 32'h0001_0000;
	localparam logic [DT_W-1:0]       ONE_TICK  = 16'h1000;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame;
		logic [FRAME_BITS-1:0] prev_frame;
		logic                  run;
		logic                  is_last;
	} frame_result_t;

	// Keeps a copy of the playback state and the queue of frames still owed by
	// the block, and grades each frame that comes out.
	class playback_scoreboard;
		logic [FRAME_BITS-1:0] length_q;
		logic [SPD_W-1:0]      speed_q;
		logic                  loop_q;
		logic                  reverse_q;
		logic [FRAME_BITS-1:0] pos_q;
		logic [FRAME_BITS-1:0] prev_q;
		logic                  running_q;
		frame_result_t         owed_frames[$];
		int                    errors;
		int                    checked;
		int                    wraps;
		int                    clamps;
		int                    useful;

		function new();
			length_q  = ONE_FRAME;
			speed_q   = 16'h0100;
			loop_q    = 1'b1;
			reverse_q = 1'b0;
			pos_q     = '0;
			prev_q    = '0;
			running_q = 1'b0;
			errors    = 0;
			checked   = 0;
			wraps     = 0;
			clamps    = 0;
			useful    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_LENGTH:  length_q = data[FRAME_BITS-1:0];
				REG_SPEED:   speed_q = data[SPD_W-1:0];
				REG_LOOP:    loop_q = data[0];
				REG_REVERSE: reverse_q = data[0];
				default: ;
			endcase
		endfunction

		function void owe_frame(logic [FRAME_BITS-1:0] frame, logic is_last);
			frame_result_t r;
			r.frame      = frame;
			r.prev_frame = prev_q;
			r.run        = running_q;
			r.is_last    = is_last;
			owed_frames.push_back(r);
		endfunction

		// Advances the model by one accepted command item.
		function void note_item(logic [ACT_W-1:0] act, logic [DT_W-1:0] dt,
				logic [FRAME_BITS-1:0] nf);
			logic [63:0] step;
			logic [63:0] len64;
			logic [63:0] pos64;
			logic [63:0] moved;
			len64 = 64'(length_q);
			pos64 = 64'(pos_q);
			// Q4.12 times Q8.8 gives Q12.20; the four low bits are dropped.
			step  = (64'(dt) * 64'(speed_q)) >> INC_SHIFT;
			moved = '0;
			case (act)
				ACT_TICK: begin
					if (running_q) begin
						useful++;
						prev_q = pos_q;
						if (!reverse_q) begin
							moved = pos64 + step;
							if (moved <= len64) begin
								pos_q = moved[FRAME_BITS-1:0];
							end else if (loop_q) begin
								wraps++;
								owe_frame(length_q, 1'b0);
								if (length_q != '0)
									moved = moved % len64;
								else
									moved = '0;
								pos_q = moved[FRAME_BITS-1:0];
							end else begin
								clamps++;
								pos_q = length_q;
								running_q = 1'b0;
							end
						end else begin
							if (step <= pos64) begin
								moved = pos64 - step;
								pos_q = moved[FRAME_BITS-1:0];
							end else if (loop_q) begin
								wraps++;
								owe_frame('0, 1'b0);
								if (length_q != '0)
									moved = len64 - ((len64 + (step - pos64)) % len64);
								else
									moved = '0;
								pos_q = moved[FRAME_BITS-1:0];
							end else begin
								clamps++;
								pos_q = '0;
								running_q = 1'b0;
							end
						end
						owe_frame(pos_q, 1'b1);
					end
				end
				ACT_PLAY: begin
					useful++;
					running_q = 1'b1;
				end
				ACT_STOP: begin
					useful++;
					running_q = 1'b0;
				end
				ACT_SETFRAME: begin
					useful++;
					prev_q = pos_q;
					pos_q  = nf;
				end
				ACT_GOSTART: begin
					useful++;
					pos_q  = '0;
					prev_q = '0;
					owe_frame(pos_q, 1'b1);
				end
				ACT_GOEND: begin
					useful++;
					pos_q  = length_q;
					prev_q = length_q;
					owe_frame(pos_q, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [FRAME_BITS-1:0] want,
				logic [FRAME_BITS-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [FRAME_BITS-1:0] frame,
				logic [FRAME_BITS-1:0] prev_frame, logic run, logic is_last);
			frame_result_t want;
			if (owed_frames.size() == 0) begin
				errors++;
				$display("%0t: frame result with none owed, expected none, got %h/%h/%b/%b",
					$time, frame, prev_frame, run, is_last);
			end else begin
				want = owed_frames.pop_front();
				checked++;
				compare_field("frame_pos", want.frame, frame);
				compare_field("previous_pos", want.prev_frame, prev_frame);
				compare_field("playing", 32'(want.run), 32'(run));
				compare_field("last", 32'(want.is_last), 32'(is_last));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [ACT_W-1:0]      action;
	logic [DT_W-1:0]       delta_time;
	logic [FRAME_BITS-1:0] new_frame;
	logic                  out_valid;
	logic                  out_stall;
	logic [FRAME_BITS-1:0] frame_pos;
	logic [FRAME_BITS-1:0] previous_pos;
	logic                  playing;
	logic                  last_result;

	// Idling on both channels is switched off for one phase to get a stretch
	// at full rate. A raised hold request makes the receiver stall for a long
	// stretch; the receiver lowers it again when the stretch is over.
	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;

	playback_scoreboard sb = new();

	animation_playback_clock dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.delta_time   (delta_time),
		.new_frame    (new_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_pos    (frame_pos),
		.previous_pos (previous_pos),
		.playing      (playing),
		.last         (last_result)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Offers one command item and returns at the edge where the block takes it.
	// The payload stays put while the block stalls. When the sender idles,
	// valid drops for a random stretch before the item is offered.
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [DT_W-1:0] dt,
			input logic [FRAME_BITS-1:0] nf);
		if (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		delta_time <= dt;
		new_frame  <= nf;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(act, dt, nf);
	endtask

	// Waits until every owed frame has come out, then lets the block finish
	// any command that gives no frame, so that registers can be written safely.
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drives one register write; the write enable stays high for the caller.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Writes all four registers back to back. The unused upper bits of the
	// narrow registers carry random junk, which the block must ignore.
	task automatic apply_settings(input logic [FRAME_BITS-1:0] len, input logic [SPD_W-1:0] spd,
			input logic lp, input logic rev);
		write_reg(REG_LENGTH, len);
		write_reg(REG_SPEED, {16'($urandom), spd});
		write_reg(REG_LOOP, {31'($urandom), lp});
		write_reg(REG_REVERSE, {31'($urandom), rev});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Sends the given number of random commands. Ticks dominate; play comes
	// often enough to restart after a clamp. Set frame mostly lands inside the
	// animation but sometimes anywhere in the 32 bits, and the fields that an
	// action ignores carry random values.
	task automatic run_phase(input int target);
		int                    pick;
		logic [ACT_W-1:0]      act;
		logic [DT_W-1:0]       dt;
		logic [FRAME_BITS-1:0] nf;
		for (int i = 0; i < target; i++) begin
			pick = $urandom_range(99);
			if ($urandom_range(1) == 1)
				dt = DT_W'($urandom);
			else
				dt = DT_W'($urandom_range(0, 16'h1800));
			nf = $urandom;
			if (pick < 58 || pick >= 96) begin
				act = ACT_TICK;
			end else if (pick < 70) begin
				act = ACT_PLAY;
			end else if (pick < 74) begin
				act = ACT_STOP;
			end else if (pick < 84) begin
				act = ACT_SETFRAME;
				if ($urandom_range(9) < 7)
					nf = $urandom_range(0, sb.length_q);
			end else if (pick < 89) begin
				act = ACT_GOSTART;
			end else if (pick < 94) begin
				act = ACT_GOEND;
			end else begin
				act = ($urandom_range(1) == 1) ? ACT_SPARE_A : ACT_SPARE_B;
			end
			send_item(act, dt, nf);
		end
	endtask

	// Every frame taken by the receiver is graded against the oldest one owed.
	// Inputs and outputs are sampled in the active region of the edge, so all
	// values are those from before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(frame_pos, previous_pos, playing, last_result);
	end

	// The receiver stalls at random, or for one long stretch on request, which
	// lets the output register fill so that the block must stall its input.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Ends the run if neither channel nor the register port moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no handshake for %0d cycles, %0d frames still owed.",
			WATCHDOG_LIMIT, sb.owed_frames.size());
		$display("FAIL animation_playback_clock");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_LENGTH;
		cfg_data   = '0;
		in_valid   = 1'b0;
		action     = ACT_TICK;
		delta_time = '0;
		new_frame  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first with the reset settings: one frame long, unit
		// speed, looping forward. A tick while stopped must give nothing.
		send_item(ACT_TICK, ONE_TICK, '0);
		send_item(ACT_GOEND, '0, '0);
		send_item(ACT_GOSTART, '0, '0);
		send_item(ACT_PLAY, '0, '0);
		// Landing exactly on the end is not past it, then two wraps, the
		// second with the largest delta.
		send_item(ACT_TICK, ONE_TICK, '0);
		send_item(ACT_TICK, 16'h0800, '0);
		send_item(ACT_TICK, 16'hFFFF, '0);
		// A frame set far beyond the length wraps on the next tick, even one
		// with zero elapsed time.
		send_item(ACT_SETFRAME, '0, 32'hFFFF_FFFF);
		send_item(ACT_TICK, '0, '0);
		// The spare action codes are ignored whatever the other fields hold.
		send_item(ACT_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(ACT_SPARE_B, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(ACT_STOP, '0, '0);

		// Clamping forward at the highest speed stops playback.
		settle_block();
		apply_settings(32'h0003_0000, 16'hFFFF, 1'b0, 1'b0);
		send_item(ACT_PLAY, '0, '0);
		send_item(ACT_TICK, 16'hFFFF, '0);
		send_item(ACT_TICK, 16'h0001, '0);

		// Backward looping: a step of exactly the length from zero wraps to
		// the length itself, and a step that lands on zero does not wrap.
		settle_block();
		apply_settings(ONE_FRAME, 16'h0100, 1'b1, 1'b1);
		send_item(ACT_GOSTART, '0, '0);
		send_item(ACT_PLAY, '0, '0);
		send_item(ACT_TICK, ONE_TICK, '0);
		send_item(ACT_TICK, 16'h0800, '0);
		send_item(ACT_TICK, 16'h0800, '0);

		// Zero length: clamping backward, then looping forward, stays at zero.
		settle_block();
		apply_settings('0, 16'h0100, 1'b0, 1'b1);
		send_item(ACT_SETFRAME, '0, 32'h0000_0100);
		send_item(ACT_TICK, ONE_TICK, '0);
		settle_block();
		apply_settings('0, 16'h0100, 1'b1, 1'b0);
		send_item(ACT_PLAY, '0, '0);
		send_item(ACT_TICK, 16'h0001, '0);

		// Largest length with zero speed: ticks do not move the position.
		settle_block();
		apply_settings(32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b0);
		send_item(ACT_GOEND, '0, '0);
		send_item(ACT_TICK, 16'hFFFF, '0);

		// Random phases, each under its own settings. The first two take the
		// extremes; the second runs without idling on either side, and the third
		// holds the receiver off for a long stretch. Lengths are mostly a few
		// frames so that wraps, and with them the divider, come often.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle_block();
			case (p)
				0: apply_settings(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
				1: apply_settings(32'h0000_0001, 16'hFFFF, 1'b0, 1'b1);
				3: apply_settings('0, 16'($urandom), 1'($urandom), 1'($urandom));
				default: begin
					if ($urandom_range(3) == 0)
						apply_settings($urandom, 16'($urandom), 1'($urandom), 1'($urandom));
					else
						apply_settings($urandom_range(ONE_FRAME / 4, 8 * ONE_FRAME),
							16'($urandom_range(16'h0040, 16'h0400)),
							1'($urandom), 1'($urandom));
				end
			endcase
			idle_on  = (p != 1);
			hold_req = (p == 2);
			run_phase(ITEMS_PER_PHASE);
		end

		settle_block();
		$display("Covered %0d state-changing commands and %0d frame results,",
			sb.useful, sb.checked);
		$display("including %0d wraps and %0d clamps, across %0d random settings.",
			sb.wraps, sb.clamps, RANDOM_PHASES);
		if (sb.errors == 0 && sb.owed_frames.size() == 0) begin
			$display("PASS animation_playback_clock");
		end else begin
			$display("FAIL animation_playback_clock");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/apc_pkg.sv
rtl/apc_divider.sv
rtl/apc_datapath.sv
rtl/apc_sequencer.sv
rtl/animation_playback_clock.sv
tb/tb_animation_playback_clock.sv
